// ===== rtl/core/range_to_nibble_block_expander_core_assert.svh =====
// Assertion macros for the range to nibble-block expander
`ifndef RANGE_TO_NIBBLE_BLOCK_EXPANDER_CORE_ASSERT_SVH
`define RANGE_TO_NIBBLE_BLOCK_EXPANDER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RTNBE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, checked out of reset
`define RTNBE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/core/rtnbe_pkg.sv =====
// Types and constants for the range to nibble-block expander
`timescale 1ns / 1ps
`default_nettype none

package rtnbe_pkg;

  localparam int MAX_BLOCKS = 32;
  localparam int CNT_W      = $clog2(MAX_BLOCKS);
  localparam logic [3:0] NIB_FULL = 4'hF;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ORDER = 6'b000010,
    ST_HINC  = 6'b000100,
    ST_PREP  = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_ADV   = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/range_to_nibble_block_expander_core.sv =====
// Range to nibble-block expander: top level with shared adder and sequencer
// Steps: ST_ORDER orders the bounds and ST_HINC adds one to the high bound,
//   then per block ST_PREP forms the gap, ST_SCAN steps one nibble at a time
//   from the cursor's lowest set nibble down until a block fits, and ST_ADV
//   advances the cursor on the shared adder; each block strobes the cycle after.
// A new range is taken only while idle, and busy is low whenever idle.
// Reset (rst, synchronous): sequencer to idle, strobe and block count cleared.
`timescale 1ns / 1ps
`default_nettype none

module range_to_nibble_block_expander_core #(
  parameter int KEY_BITS = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  wire  [KEY_BITS-1:0] range_low,
  input  wire  [KEY_BITS-1:0] range_high,
  output logic                entry_valid,
  output logic [KEY_BITS-1:0] entry_low,
  output logic [KEY_BITS-1:0] entry_high,
  output logic                last_entry
);

`include "range_to_nibble_block_expander_core_assert.svh"

  localparam int NIBS  = (KEY_BITS - 1) / 4 + 1;
  localparam int WORD  = NIBS * 4;
  localparam int IDX_W = $clog2(NIBS);

  rtnbe_pkg::state_t state;

  logic [WORD-1:0]             cur;
  logic [WORD:0]               hi1;
  logic [WORD:0]               gap;
  logic [WORD-1:0]             blk_end;
  logic [IDX_W-1:0]            idx;
  logic [rtnbe_pkg::CNT_W-1:0] count;

  // shared adder
  logic [WORD:0] add_a;
  logic [WORD:0] add_b;
  logic          add_cin;
  logic [WORD:0] add_sum;

  always_comb begin
    add_a   = hi1;
    add_b   = '0;
    add_cin = 1'b0;
    unique case (state)
      rtnbe_pkg::ST_ORDER, rtnbe_pkg::ST_PREP: begin
        add_b   = ~{1'b0, cur};
        add_cin = 1'b1;
      end
      rtnbe_pkg::ST_HINC: begin
        add_cin = 1'b1;
      end
      rtnbe_pkg::ST_ADV: begin
        add_a   = {1'b0, blk_end};
        add_cin = 1'b1;
      end
      default: begin
        add_cin = 1'b0;
      end
    endcase
  end

  assign add_sum = add_a + add_b + (WORD + 1)'(add_cin);

  // lowest nonzero nibble of the cursor, top nibble when none below it
  logic [IDX_W-1:0] start_idx;

  always_comb begin
    start_idx = IDX_W'(NIBS - 1);
    for (int m = NIBS - 2; m >= 0; m--) begin
      if (cur[m*4 +: 4] != 4'h0) begin
        start_idx = IDX_W'(m);
      end
    end
  end

  // fit test at the current nibble
  logic [3:0]      gap_nib;
  logic [3:0]      cur_nib;
  logic            above;
  logic            fit;
  logic [4:0]      span_q;
  logic [3:0]      span_k;
  logic [WORD-1:0] end_cand;

  always_comb begin
    gap_nib = gap[idx*4 +: 4];
    cur_nib = cur[idx*4 +: 4];
    above   = gap[WORD];
    for (int m = 0; m < NIBS; m++) begin
      if (m > int'(idx) && gap[m*4 +: 4] != 4'h0) begin
        above = 1'b1;
      end
    end
    fit    = above || (gap_nib != 4'h0);
    span_q = {1'b0, gap_nib} + {1'b0, cur_nib};
    if (above || span_q[4]) begin
      span_k = rtnbe_pkg::NIB_FULL;
    end else begin
      span_k = span_q[3:0] - 4'd1;
    end
    for (int m = 0; m < NIBS; m++) begin
      if (m < int'(idx)) begin
        end_cand[m*4 +: 4] = rtnbe_pkg::NIB_FULL;
      end else if (m == int'(idx)) begin
        end_cand[m*4 +: 4] = span_k;
      end else begin
        end_cand[m*4 +: 4] = cur[m*4 +: 4];
      end
    end
  end

  logic last_now;
  assign last_now = (add_sum == hi1) ||
                    (count == rtnbe_pkg::CNT_W'(rtnbe_pkg::MAX_BLOCKS - 1));

  assign busy = (state != rtnbe_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rtnbe_pkg::ST_IDLE;
      entry_valid <= 1'b0;
      count       <= '0;
    end else begin
      entry_valid <= 1'b0;
      unique case (state)
        rtnbe_pkg::ST_IDLE: begin
          if (start) begin
            cur   <= WORD'(range_low);
            hi1   <= (WORD + 1)'(range_high);
            count <= '0;
            state <= rtnbe_pkg::ST_ORDER;
          end
        end
        rtnbe_pkg::ST_ORDER: begin
          if (add_sum[WORD]) begin
            cur <= hi1[WORD-1:0];
            hi1 <= {1'b0, cur};
          end
          state <= rtnbe_pkg::ST_HINC;
        end
        rtnbe_pkg::ST_HINC: begin
          hi1   <= add_sum;
          state <= rtnbe_pkg::ST_PREP;
        end
        rtnbe_pkg::ST_PREP: begin
          gap   <= add_sum;
          idx   <= start_idx;
          state <= rtnbe_pkg::ST_SCAN;
        end
        rtnbe_pkg::ST_SCAN: begin
          if (fit) begin
            blk_end <= end_cand;
            state   <= rtnbe_pkg::ST_ADV;
          end else begin
            idx <= idx - IDX_W'(1);
          end
        end
        rtnbe_pkg::ST_ADV: begin
          entry_valid <= 1'b1;
          entry_low   <= cur[KEY_BITS-1:0];
          entry_high  <= blk_end[KEY_BITS-1:0];
          last_entry  <= last_now;
          cur         <= add_sum[WORD-1:0];
          count       <= count + rtnbe_pkg::CNT_W'(1);
          state       <= last_now ? rtnbe_pkg::ST_IDLE : rtnbe_pkg::ST_PREP;
        end
        default: begin
          state <= rtnbe_pkg::ST_IDLE;
        end
      endcase
    end
  end

  `RTNBE_ASSERT_NOW(a_last_frees, entry_valid && last_entry, !busy)
  `RTNBE_ASSERT_NOW(a_more_busy, entry_valid && !last_entry, busy)
  `RTNBE_ASSERT_NOW(a_ordered, entry_valid, entry_low <= entry_high)
  `RTNBE_ASSERT_NEXT(a_take, start && !busy, busy && !entry_valid)

endmodule

`default_nettype wire

// ===== tb/range_to_nibble_block_expander_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the range to nibble-block expander core
module range_to_nibble_block_expander_core_test;

  localparam int KEY_BITS = 64;
  localparam int TOP_NIB = ((KEY_BITS - 1) / 4) * 4;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int RANGES_PER_PHASE = 60;
  localparam int REPORT_MAX = 10;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef struct packed {
    key_t lo;
    key_t hi;
    logic last;
  } block_t;

  localparam key_t ALL_ONES = '1;

  class nibble_block_board;
    block_t pending_blocks[$];
    int mismatches;
    int failures;

    function new();
      mismatches = 0;
      failures = 0;
    endfunction

    // end of the longest single block starting at cur that stays within hi
    static function key_t widest_end(key_t cur, key_t hi);
      int first_nib;
      int j;
      int k;
      key_t base;
      key_t fin;
      first_nib = TOP_NIB;
      if (cur != '0) begin
        for (first_nib = 0; first_nib < TOP_NIB; first_nib += 4) begin
          if (cur[first_nib +: 4] != 4'h0) break;
        end
      end
      for (j = first_nib; j >= 0; j -= 4) begin
        base = cur & ~(key_t'(rtnbe_pkg::NIB_FULL) << j);
        for (k = 15; k >= int'(cur[j +: 4]); k--) begin
          fin = base + (((key_t'(k) + key_t'(1)) << j) - key_t'(1));
          if (fin <= hi) return fin;
        end
      end
      return cur;
    endfunction

    function void note_range(key_t a, key_t b);
      key_t lo;
      key_t hi;
      key_t cur;
      key_t fin;
      block_t blk;
      int n;
      lo = a;
      hi = b;
      if (lo > hi) begin
        lo = b;
        hi = a;
      end
      cur = lo;
      for (n = 0; n < rtnbe_pkg::MAX_BLOCKS; n++) begin
        fin = widest_end(cur, hi);
        blk.lo = cur;
        blk.hi = fin;
        blk.last = (fin >= hi) || (n == rtnbe_pkg::MAX_BLOCKS - 1);
        pending_blocks.push_back(blk);
        if (blk.last) break;
        cur = fin + key_t'(1);
      end
    endfunction

    function void check_block(key_t lo, key_t hi, logic last);
      block_t want;
      if (pending_blocks.size() == 0) begin
        mismatches++;
        failures++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected block: low %h high %h last %b", lo, hi, last);
        return;
      end
      want = pending_blocks.pop_front();
      if (want.lo !== lo || want.hi !== hi || want.last !== last) begin
        mismatches++;
        failures++;
        if (mismatches <= REPORT_MAX)
          $display("block mismatch: expected low %h high %h last %b, got low %h high %h last %b",
                   want.lo, want.hi, want.last, lo, hi, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  key_t range_low = '0;
  key_t range_high = '0;
  logic busy;
  logic entry_valid;
  key_t entry_low;
  key_t entry_high;
  logic last_entry;

  nibble_block_board board;
  int sender_idle_pct = 16;
  int unsigned cycle_count = 0;

  range_to_nibble_block_expander_core #(
    .KEY_BITS(KEY_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .range_low(range_low),
    .range_high(range_high),
    .entry_valid(entry_valid),
    .entry_low(entry_low),
    .entry_high(entry_high),
    .last_entry(last_entry)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && entry_valid) board.check_block(entry_low, entry_high, last_entry);
  end

  // called at a falling edge; returns at a falling edge
  task automatic issue_range(key_t a, key_t b);
    start <= 1'b1;
    range_low <= a;
    range_high <= b;
    do @(posedge clk); while (busy);
    board.note_range(a, b);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      range_low <= {$urandom, $urandom};
      range_high <= {$urandom, $urandom};
      @(negedge clk);
    end
  endtask

  task automatic drain_blocks();
    start <= 1'b0;
    @(negedge clk);
    while (board.pending_blocks.size() != 0 || busy) @(negedge clk);
  endtask

  function automatic void random_range(output key_t a, output key_t b);
    key_t r;
    key_t mask;
    key_t t;
    int s;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        a = r;
        b = {$urandom, $urandom};
      end
      4, 5: begin
        a = r;
        b = r + ({$urandom, $urandom} >> $urandom_range(63));
        if (b < a) b = ALL_ONES;
      end
      6: begin
        s = $urandom_range(15);
        mask = ~(ALL_ONES << (4 * s));
        a = r & ~mask;
        b = (a | mask) - key_t'($urandom_range(3));
      end
      7: begin
        a = r;
        b = r;
      end
      8: begin
        a = key_t'($urandom_range(255));
        b = ALL_ONES - key_t'($urandom_range(255));
      end
      default: begin
        a = r | (key_t'(1) << (KEY_BITS - 1));
        b = {$urandom, $urandom} & ~(key_t'(1) << (KEY_BITS - 1));
      end
    endcase
    if ($urandom_range(3) == 0) begin
      t = a;
      a = b;
      b = t;
    end
  endfunction

  initial begin
    int phase;
    int i;
    key_t a;
    key_t b;
    board = new();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    sender_idle_pct = 16;
    issue_range('0, ALL_ONES);
    issue_range(ALL_ONES, '0);
    issue_range('0, '0);
    issue_range(ALL_ONES, ALL_ONES);
    issue_range(64'h0123_4567_89ab_cdef, 64'h0123_4567_89ab_cdef);
    issue_range(64'h5, 64'h3);
    issue_range(64'h0, 64'hf);
    issue_range(64'h1, 64'he);
    issue_range(64'h10, 64'h1f);
    issue_range(64'h1, ALL_ONES - 64'h1);
    issue_range(64'h1, ALL_ONES);
    issue_range('0, ALL_ONES - 64'h1);
    issue_range(64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
    issue_range(64'h0fff_ffff_ffff_ffff, 64'h1000_0000_0000_0000);
    issue_range(64'h1234_5678_9abc_def0, 64'hfedc_ba98_7654_3210);
    issue_range(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    issue_range(64'hf000_0000_0000_0000, ALL_ONES);
    issue_range(64'h0000_0000_0000_0011, 64'hffff_ffff_ffff_ffee);
    drain_blocks();

    for (phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 71 : 0;
      for (i = 0; i < RANGES_PER_PHASE; i++) begin
        random_range(a, b);
        issue_range(a, b);
      end
      drain_blocks();
    end

    repeat (40) @(negedge clk);
    board.failures += board.pending_blocks.size();
    if (board.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rtnbe_pkg.sv
rtl/core/range_to_nibble_block_expander_core.sv
tb/range_to_nibble_block_expander_core_test.sv
